// ----- rtl/core/fop_pkg.sv -----
// Shared types, constants and field tables for the forward open request parser.
// No dependencies; fop_step, fop_queue and the top level refer to it by scoped names.
package fop_pkg;

  localparam logic [5:0] HDR_NORMAL = 6'd36;
  localparam logic [5:0] HDR_LARGE  = 6'd40;
  localparam int         NUM_FIELDS = 14;

  // result kinds
  localparam logic [2:0] KIND_FIELD = 3'd0;
  localparam logic [2:0] KIND_PATH  = 3'd1;
  localparam logic [2:0] KIND_DONE  = 3'd2;
  localparam logic [2:0] KIND_SHORT = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  // header field tags that need special handling
  localparam logic [3:0] TAG_OT_PARAMS = 4'd9;
  localparam logic [3:0] TAG_TO_PARAMS = 4'd11;
  localparam logic [3:0] TAG_PATH_SIZE = 4'd13;

  // field start offset and length, indexed [layout][tag]
  localparam logic [5:0] FLD_START [2][NUM_FIELDS] = '{
    '{6'd0, 6'd1, 6'd2, 6'd6, 6'd10, 6'd12, 6'd14, 6'd18, 6'd22, 6'd26, 6'd28, 6'd32,
      6'd34, 6'd35},
    '{6'd0, 6'd1, 6'd2, 6'd6, 6'd10, 6'd12, 6'd14, 6'd18, 6'd22, 6'd26, 6'd30, 6'd34,
      6'd38, 6'd39}
  };
  localparam logic [2:0] FLD_LEN [2][NUM_FIELDS] = '{
    '{3'd1, 3'd1, 3'd4, 3'd4, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd2, 3'd4, 3'd2, 3'd1, 3'd1},
    '{3'd1, 3'd1, 3'd4, 3'd4, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1, 3'd1}
  };

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  field_tag;
    logic [31:0] field_value;
    logic        owner_flag;
    logic [1:0]  conn_kind;
    logic [1:0]  connection_priority;
    logic        variable_size;
    logic [15:0] conn_size;
    logic [9:0]  consumed_bytes;
    logic        last_result;
  } res_t;

  // up to two results pushed into the output queue per byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [9:0]  offset;
    logic        long_fmt;
    logic [31:0] acc;
    logic [7:0]  path_words;
    logic        finished;
  } pstate_t;

  // Splits a network connection parameter word into its subfields.
  function automatic res_t decode_params(input res_t r, input logic long_fmt);
    res_t o;
    o = r;
    if (long_fmt) begin
      o.owner_flag          = r.field_value[31];
      o.conn_kind           = r.field_value[30:29];
      o.connection_priority = r.field_value[27:26];
      o.variable_size       = r.field_value[25];
      o.conn_size           = r.field_value[15:0];
    end else begin
      o.owner_flag          = r.field_value[15];
      o.conn_kind           = r.field_value[14:13];
      o.connection_priority = r.field_value[11:10];
      o.variable_size       = r.field_value[9];
      o.conn_size           = {7'd0, r.field_value[8:0]};
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/fop_if.sv -----
// Valid/ready channel interfaces for the parser's byte input and result output.
// Depends on nothing; the top level uses one instance of each.
interface fop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       large_format;
  logic       frame_end;

  modport source (output valid, output data_byte, output large_format, output frame_end,
                  input ready);
  modport sink   (input valid, input data_byte, input large_format, input frame_end,
                  output ready);
endinterface

interface fop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  field_tag;
  logic [31:0] field_value;
  logic        owner_flag;
  logic [1:0]  conn_kind;
  logic [1:0]  connection_priority;
  logic        variable_size;
  logic [15:0] conn_size;
  logic [9:0]  consumed_bytes;
  logic        last_result;

  modport source (output valid, output result_kind, output field_tag, output field_value,
                  output owner_flag, output conn_kind,
                  output connection_priority, output variable_size,
                  output conn_size, output consumed_bytes, output last_result,
                  input ready);
  modport sink   (input valid, input result_kind, input field_tag, input field_value,
                  input owner_flag, input conn_kind,
                  input connection_priority, input variable_size,
                  input conn_size, input consumed_bytes, input last_result,
                  output ready);
endinterface

// ----- rtl/core/fop_step.sv -----
// One parser step: takes the current byte and parser state, gives next state
// and up to two results. Pure combinational; uses fop_pkg.
module fop_step (
  input  fop_pkg::pstate_t st,
  input  logic [7:0]       data_byte,
  input  logic             large_format,
  input  logic             frame_end,
  output fop_pkg::pstate_t st_nxt,
  output fop_pkg::push_t   push
);

  logic        lat;
  logic [5:0]  hdr;
  logic        in_hdr;
  logic [5:0]  off6;
  logic        hit;
  logic [3:0]  tag;
  logic [1:0]  pos;
  logic        fld_last;
  logic [31:0] acc_nxt;
  logic        field_res;
  logic [7:0]  pw_eff;
  logic [10:0] off_p1;
  logic        done;
  logic        err;
  logic        prim;
  logic        sec;
  fop_pkg::res_t prim_r;
  fop_pkg::res_t sec_r;

  always_comb begin
    lat    = (st.offset == 10'd0) ? large_format : st.long_fmt;
    hdr    = lat ? fop_pkg::HDR_LARGE : fop_pkg::HDR_NORMAL;
    in_hdr = st.offset < {4'd0, hdr};
    off6   = st.offset[5:0];
    off_p1 = {1'b0, st.offset} + 11'd1;

    // fields never overlap, so at most one entry matches
    hit      = 1'b0;
    tag      = '0;
    pos      = '0;
    fld_last = 1'b0;
    for (int t = 0; t < fop_pkg::NUM_FIELDS; t++) begin
      if (off6 >= fop_pkg::FLD_START[lat][t] &&
          {1'b0, off6} < {1'b0, fop_pkg::FLD_START[lat][t]} +
                         {4'd0, fop_pkg::FLD_LEN[lat][t]}) begin
        hit      = 1'b1;
        tag      = 4'(t);
        pos      = 2'(off6 - fop_pkg::FLD_START[lat][t]);
        fld_last = ({1'b0, pos} + 3'd1) == fop_pkg::FLD_LEN[lat][t];
      end
    end

    acc_nxt = (pos == 2'd0) ? {24'd0, data_byte}
                            : st.acc | ({24'd0, data_byte} << {pos, 3'b000});
    field_res = in_hdr && hit && fld_last;
    pw_eff    = (field_res && tag == fop_pkg::TAG_PATH_SIZE) ? data_byte : st.path_words;

    if (in_hdr)
      done = (off_p1 == {5'd0, hdr}) && (pw_eff == 8'd0);
    else
      done = off_p1 == ({5'd0, hdr} + {2'd0, pw_eff, 1'b0});
    err  = frame_end && !done;
    prim = !st.finished && (field_res || !in_hdr);
    sec  = !st.finished && (done || err);

    prim_r = '0;
    if (in_hdr) begin
      prim_r.result_kind = fop_pkg::KIND_FIELD;
      prim_r.field_tag   = tag;
      prim_r.field_value = acc_nxt;
      if (tag == fop_pkg::TAG_OT_PARAMS || tag == fop_pkg::TAG_TO_PARAMS)
        prim_r = fop_pkg::decode_params(prim_r, lat);
    end else begin
      prim_r.result_kind = fop_pkg::KIND_PATH;
      prim_r.field_value = {24'd0, data_byte};
    end

    sec_r = '0;
    if (done) begin
      sec_r.result_kind    = fop_pkg::KIND_DONE;
      sec_r.consumed_bytes = off_p1[9:0];
    end else if (off_p1 < {5'd0, hdr}) begin
      sec_r.result_kind = fop_pkg::KIND_SHORT;
    end else begin
      sec_r.result_kind = fop_pkg::KIND_TRUNC;
    end
    sec_r.last_result = 1'b1;
    prim_r.last_result = !sec;

    push.n  = {1'b0, prim} + {1'b0, sec};
    push.r0 = prim ? prim_r : sec_r;
    push.r1 = sec_r;

    st_nxt = st;
    if (!st.finished) begin
      st_nxt.offset     = off_p1[9:0];
      st_nxt.long_fmt   = lat;
      st_nxt.path_words = pw_eff;
      st_nxt.finished   = done;
      if (in_hdr && hit)
        st_nxt.acc = acc_nxt;
    end
    if (frame_end)
      st_nxt = '0;
  end

endmodule

// ----- rtl/core/fop_queue.sv -----
// Four-entry result queue: takes up to two results a cycle, gives one per transfer.
// Uses fop_pkg types.
module fop_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  fop_pkg::push_t  push,
  output logic            space2,
  output logic            head_valid,
  input  logic            head_ready,
  output fop_pkg::res_t   head
);

  fop_pkg::res_t q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign head_valid = count_r != 3'd0;
  assign head       = q_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  assign space2     = count_r <= 3'd2;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.n} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0)
      q_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2)
      q_r[wr_ptr_r + 2'd1] <= push.r1;
  end

endmodule

// ----- rtl/core/forward_open_request_parser.sv -----
// Forward open request parser, one byte per transfer, results through a 4-deep queue.
// A byte is registered, then its results enter the queue. Throughput: one byte per cycle
// while the queue has room for two results; a byte with two results needs two output
// transfers, absorbed by the queue, so rate is bounded by the output's one result/cycle.
// Reset: synchronous active-low rst_n clears parser state, input stage and queue at once.
// Depends on fop_pkg, fop_if, fop_step and fop_queue.
module forward_open_request_parser (
  input logic           clk,
  input logic           rst_n,
  fop_in_if.sink        in_ch,
  fop_out_if.source     out_ch
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_large_r;
  logic             s1_end_r;
  fop_pkg::pstate_t st_r;
  fop_pkg::pstate_t st_nxt;
  fop_pkg::push_t   step_push;
  fop_pkg::push_t   q_push;
  fop_pkg::res_t    head;
  logic             space2;
  logic             advance;
  logic             in_xfer;

  assign advance     = s1_valid_r && space2;
  assign in_ch.ready = !s1_valid_r || space2;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  fop_step u_step (
    .st           (st_r),
    .data_byte    (s1_byte_r),
    .large_format (s1_large_r),
    .frame_end    (s1_end_r),
    .st_nxt       (st_nxt),
    .push         (step_push)
  );

  always_comb begin
    q_push = step_push;
    if (!advance)
      q_push.n = 2'd0;
  end

  fop_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .space2     (space2),
    .head_valid (out_ch.valid),
    .head_ready (out_ch.ready),
    .head       (head)
  );

  assign out_ch.result_kind         = head.result_kind;
  assign out_ch.field_tag           = head.field_tag;
  assign out_ch.field_value         = head.field_value;
  assign out_ch.owner_flag          = head.owner_flag;
  assign out_ch.conn_kind           = head.conn_kind;
  assign out_ch.connection_priority = head.connection_priority;
  assign out_ch.variable_size       = head.variable_size;
  assign out_ch.conn_size           = head.conn_size;
  assign out_ch.consumed_bytes      = head.consumed_bytes;
  assign out_ch.last_result         = head.last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      st_r       <= '0;
    end else begin
      if (in_xfer)
        s1_valid_r <= 1'b1;
      else if (advance)
        s1_valid_r <= 1'b0;
      if (advance)
        st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_large_r <= in_ch.large_format;
      s1_end_r   <= in_ch.frame_end;
    end
  end

endmodule
